// ===== hdl/lzfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzfd_pkg: shared types and constants
// Constants and status codes for the flag-group LZ decompressor.
// ----------------------------------------------------------------------------
package lzfd_pkg;

  localparam int unsigned SizeBits  = 32;
  localparam int unsigned LaneBytes = 8;
  localparam int unsigned WinBits   = 12;
  localparam int unsigned HeaderLen = 16;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadMag  = 2'd1,
    StBadRef  = 2'd2,
    StTrunc   = 2'd3
  } status_e;

  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] m;
    case (pos)
      2'd0:    m = 8'h59;
      2'd1:    m = 8'h61;
      2'd2:    m = 8'h7A;
      default: m = 8'h30;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/lzfd_window.sv =====
// ----------------------------------------------------------------------------
// lzfd_window: history store
// 4096 x 8 synchronous memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lzfd_window (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [lzfd_pkg::WinBits-1:0] waddr_i,
  input  logic [7:0]                   wdata_i,
  input  logic [lzfd_pkg::WinBits-1:0] raddr_i,
  output logic [7:0]                   rdata_o
);

  logic [7:0] mem_q [2**lzfd_pkg::WinBits];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/lz_flag_group_decompressor.sv =====
// ----------------------------------------------------------------------------
// lz_flag_group_decompressor: streaming flag-group LZ77 decompressor
// Parses header, flag bytes and tokens; copies from a 4096-byte history store.
// ----------------------------------------------------------------------------
// Header, flag and literal bytes are each taken as one input beat; a back-reference
// stalls the input while each copied byte is read from the history memory
// (registered read) and then written back before the next read.
// A full beat that meets end of input is followed by a separate truncation beat.
// A result waits in an output register; processing stalls only while it is full.
// Reset (rst_ni low, asynchronous) clears all control state; history is unset.
module lz_flag_group_decompressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_bytes_o,
  output logic [3:0]  byte_count_o,
  output logic        last_o,
  output logic [1:0]  status_o
);

  localparam int unsigned WB = lzfd_pkg::WinBits;
  localparam int unsigned SB = lzfd_pkg::SizeBits;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_WRIT = 2'd2;
  localparam logic [1:0] S_TAIL = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [WB-1:0] wptr_q, wptr_d;
  logic [SB-1:0] prod_q, prod_d, size_q, size_d;
  logic [4:0]    hpos_q, hpos_d;
  logic [7:0]    flag_q, flag_d;
  logic [3:0]    fleft_q, fleft_d;
  logic [1:0]    phase_q, phase_d;
  logic [7:0]    pf_q, pf_d, ps_q, ps_d;
  logic [63:0]   pack_q, pack_d;
  logic [3:0]    fill_q, fill_d;
  logic          fin_q, fin_d;
  logic [8:0]    cnt_q, cnt_d;
  logic [WB-1:0] dist_q, dist_d;
  logic          eoi_q, eoi_d;

  logic          ov_q, ov_d;
  logic [63:0]   ob_q, ob_d;
  logic [3:0]    oc_q, oc_d;
  logic          ol_q, ol_d;
  logic [1:0]    os_q, os_d;

  logic          we;
  logic [7:0]    wdata, rdata;
  logic [WB-1:0] raddr;

  lzfd_window u_window (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wptr_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic out_free, accept;
  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    logic [SB-1:0] prod_n;
    logic [8:0]    len;
    logic [12:0]   ref_dist;
    logic          do_push, do_copy, fin_now;
    logic [1:0]    fstat;
    logic [7:0]    pbyte;
    state_d = state_q; wptr_d = wptr_q; prod_d = prod_q; size_d = size_q;
    hpos_d = hpos_q; flag_d = flag_q; fleft_d = fleft_q; phase_d = phase_q;
    pf_d = pf_q; ps_d = ps_q; pack_d = pack_q; fill_d = fill_q; fin_d = fin_q;
    cnt_d = cnt_q; dist_d = dist_q; eoi_d = eoi_q;
    ov_d = ov_q && out_stall_i; ob_d = ob_q; oc_d = oc_q; ol_d = ol_q; os_d = os_q;
    we = 1'b0; wdata = 8'd0; raddr = wptr_q - dist_q;
    do_push = 1'b0; do_copy = 1'b0; fin_now = 1'b0; fstat = lzfd_pkg::StOk;
    pbyte = in_byte_i; len = 9'd0; ref_dist = 13'd0; prod_n = prod_q;

    if (accept && !fin_q) begin
      if (hpos_q < 5'(lzfd_pkg::HeaderLen)) begin
        if (hpos_q < 5'd4 && in_byte_i != lzfd_pkg::magic_byte(hpos_q[1:0])) begin
          fin_now = 1'b1; fstat = lzfd_pkg::StBadMag;
        end else begin
          if (hpos_q >= 5'd4 && hpos_q < 5'd8) size_d = {size_q[SB-9:0], in_byte_i};
          hpos_d = hpos_q + 5'd1;
          if (hpos_q == 5'(lzfd_pkg::HeaderLen - 1) && size_q == '0) begin
            fin_now = 1'b1;
          end
        end
      end else if (phase_q == 2'd0) begin
        if (fleft_q == 4'd0) begin
          flag_d = in_byte_i; fleft_d = 4'd8;
        end else if (flag_q[7]) begin
          flag_d = {flag_q[6:0], 1'b0}; fleft_d = fleft_q - 4'd1;
          do_push = 1'b1;
        end else begin
          pf_d = in_byte_i; phase_d = 2'd1;
        end
      end else if (phase_q == 2'd1) begin
        ps_d = in_byte_i;
        if (pf_q[7:4] != 4'd0) begin
          do_copy = 1'b1; len = 9'(pf_q[7:4]) + 9'd2;
        end else begin
          phase_d = 2'd2;
        end
      end else begin
        do_copy = 1'b1; len = 9'(in_byte_i) + 9'h12;
      end

      if (do_copy) begin
        ref_dist = {1'b0, pf_q[3:0], (phase_q == 2'd1) ? in_byte_i : ps_q} + 13'd1;
        flag_d = {flag_q[6:0], 1'b0}; fleft_d = fleft_q - 4'd1; phase_d = 2'd0;
        if (SB'(ref_dist) > prod_q || SB'(len) > size_q - prod_q) begin
          fin_now = 1'b1; fstat = lzfd_pkg::StBadRef;
        end else begin
          cnt_d = len; dist_d = ref_dist[WB-1:0]; eoi_d = end_of_input_i;
          state_d = S_READ;
        end
      end

      if (do_push) begin
        we = 1'b1; wdata = pbyte; wptr_d = wptr_q + WB'(1);
        prod_n = prod_q + SB'(1); prod_d = prod_n;
        pack_d = pack_q | (64'(pbyte) << {fill_q[2:0], 3'b000});
        fill_d = fill_q + 4'd1;
        if (prod_n >= size_q) begin
          ov_d = 1'b1; ob_d = pack_d; oc_d = fill_d; ol_d = 1'b1; os_d = lzfd_pkg::StOk;
          pack_d = '0; fill_d = '0; fin_d = 1'b1;
        end else if (fill_d >= 4'(lzfd_pkg::LaneBytes)) begin
          ov_d = 1'b1; ob_d = pack_d; oc_d = fill_d; ol_d = 1'b0; os_d = lzfd_pkg::StOk;
          pack_d = '0; fill_d = '0;
          if (end_of_input_i) state_d = S_TAIL;
        end else if (end_of_input_i) begin
          ov_d = 1'b1; ob_d = pack_d; oc_d = fill_d; ol_d = 1'b1;
          os_d = lzfd_pkg::StTrunc; pack_d = '0; fill_d = '0; fin_d = 1'b1;
        end
      end else if (!fin_now && state_d == S_IDLE && end_of_input_i) begin
        fin_now = 1'b1; fstat = lzfd_pkg::StTrunc;
      end

      if (fin_now) begin
        ov_d = 1'b1; ob_d = pack_q; oc_d = fill_q; ol_d = 1'b1; os_d = fstat;
        pack_d = '0; fill_d = '0; fin_d = 1'b1;
      end
    end else if (state_q == S_READ) begin
      state_d = S_WRIT;
    end else if (state_q == S_WRIT && out_free) begin
      we = 1'b1; wdata = rdata; wptr_d = wptr_q + WB'(1);
      prod_n = prod_q + SB'(1); prod_d = prod_n;
      pack_d = pack_q | (64'(rdata) << {fill_q[2:0], 3'b000});
      fill_d = fill_q + 4'd1;
      cnt_d = cnt_q - 9'd1;
      state_d = S_READ;
      if (prod_n >= size_q) begin
        ov_d = 1'b1; ob_d = pack_d; oc_d = fill_d; ol_d = 1'b1; os_d = lzfd_pkg::StOk;
        pack_d = '0; fill_d = '0; fin_d = 1'b1; state_d = S_IDLE;
      end else if (fill_d >= 4'(lzfd_pkg::LaneBytes)) begin
        ov_d = 1'b1; ob_d = pack_d; oc_d = fill_d; ol_d = 1'b0; os_d = lzfd_pkg::StOk;
        pack_d = '0; fill_d = '0;
        if (cnt_d == 9'd0) state_d = eoi_q ? S_TAIL : S_IDLE;
      end else if (cnt_d == 9'd0) begin
        state_d = S_IDLE;
        if (eoi_q) begin
          ov_d = 1'b1; ob_d = pack_d; oc_d = fill_d; ol_d = 1'b1;
          os_d = lzfd_pkg::StTrunc; pack_d = '0; fill_d = '0; fin_d = 1'b1;
        end
      end
    end else if (state_q == S_TAIL && out_free) begin
      ov_d = 1'b1; ob_d = pack_q; oc_d = fill_q; ol_d = 1'b1; os_d = lzfd_pkg::StTrunc;
      pack_d = '0; fill_d = '0; fin_d = 1'b1; state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; wptr_q <= '0; prod_q <= '0; size_q <= '0; hpos_q <= '0;
      flag_q <= '0; fleft_q <= '0; phase_q <= '0; pf_q <= '0; ps_q <= '0;
      pack_q <= '0; fill_q <= '0; fin_q <= 1'b0; cnt_q <= '0; dist_q <= '0;
      eoi_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; wptr_q <= wptr_d; prod_q <= prod_d; size_q <= size_d;
      hpos_q <= hpos_d; flag_q <= flag_d; fleft_q <= fleft_d; phase_q <= phase_d;
      pf_q <= pf_d; ps_q <= ps_d; pack_q <= pack_d; fill_q <= fill_d;
      fin_q <= fin_d; cnt_q <= cnt_d; dist_q <= dist_d; eoi_q <= eoi_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d; oc_q <= oc_d; ol_q <= ol_d; os_q <= os_d;
  end

  assign out_valid_o  = ov_q;
  assign out_bytes_o  = ob_q;
  assign byte_count_o = oc_q;
  assign last_o       = ol_q;
  assign status_o     = os_q;

endmodule

// ===== hdl/lzfd_checker.sv =====
// ----------------------------------------------------------------------------
// lzfd_port_checker: port-level checks
// Watches the decompressor's ports and flags protocol and result slips.
// ----------------------------------------------------------------------------
module lzfd_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] out_bytes_o,
  input logic [3:0]  byte_count_o,
  input logic        last_o,
  input logic [1:0]  status_o
);

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && last_o) begin
      done_q <= 1'b1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_bytes_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_count_o <= 4'(lzfd_pkg::LaneBytes))
    else $error("byte count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != lzfd_pkg::StOk |-> last_o)
    else $error("error status without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !out_valid_o)
    else $error("result after end of stream");

endmodule

bind lz_flag_group_decompressor lzfd_port_checker u_lzfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_bytes_o  (out_bytes_o),
  .byte_count_o (byte_count_o),
  .last_o       (last_o),
  .status_o     (status_o)
);

// ===== test/lzfd_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzfd_checker: decompressed-stream scoreboard
// Watches the compressed-byte and output channels, rebuilds the expected
// packed output beats from the accepted bytes and compares them in order.
// ----------------------------------------------------------------------------
module lzfd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_input_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] out_bytes_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_i,
  input  logic [1:0]  status_i,
  output int          fail_count_o,
  output int          pending_count_o,
  output int          beat_count_o
);

  typedef struct packed {
    logic [63:0]       data;
    logic [3:0]        cnt;
    logic              last;
    lzfd_pkg::status_e st;
  } out_beat_t;

  out_beat_t   expected_q[$];
  logic [7:0]  hist_mem[4096];
  logic [11:0] wr_ptr;
  logic [31:0] produced, out_size;
  logic [4:0]  hdr_pos;
  logic [7:0]  flags;
  logic [3:0]  flags_left;
  logic [1:0]  phase;
  logic [7:0]  tok_first, tok_second;
  logic [63:0] lane_buf;
  logic [3:0]  lane_fill;
  logic        done;

  initial begin
    fail_count_o = 0;
    beat_count_o = 0;
    wr_ptr = '0; produced = '0; out_size = '0; hdr_pos = '0;
    flags = '0; flags_left = '0; phase = '0;
    tok_first = '0; tok_second = '0; lane_buf = '0; lane_fill = '0; done = 1'b0;
  end

  assign pending_count_o = expected_q.size();

  task automatic put_beat(input logic last, input lzfd_pkg::status_e st);
    out_beat_t b;
    b.data = lane_buf;
    b.cnt  = lane_fill;
    b.last = last;
    b.st   = st;
    expected_q.push_back(b);
    lane_buf  = '0;
    lane_fill = '0;
  endtask

  task automatic end_stream(input lzfd_pkg::status_e st);
    done = 1'b1;
    put_beat(1'b1, st);
  endtask

  task automatic append_byte(input logic [7:0] b);
    hist_mem[wr_ptr] = b;
    wr_ptr = wr_ptr + 12'd1;
    lane_buf = lane_buf | (64'(b) << (8 * lane_fill[2:0]));
    lane_fill = lane_fill + 4'd1;
    produced = produced + 32'd1;
    if (produced >= out_size) end_stream(lzfd_pkg::StOk);
    else if (lane_fill >= lzfd_pkg::LaneBytes) put_beat(1'b0, lzfd_pkg::StOk);
  endtask

  task automatic next_flag();
    flags = flags << 1;
    if (flags_left != 0) flags_left = flags_left - 4'd1;
    phase = 2'd0;
  endtask

  task automatic copy_back(input logic [31:0] len);
    logic [31:0] ref_dist;
    ref_dist = {20'd0, tok_first[3:0], tok_second} + 32'd1;
    next_flag();
    if (ref_dist > produced || len > out_size - produced) begin
      end_stream(lzfd_pkg::StBadRef);
    end else begin
      for (int i = 0; i < len && !done; i++) append_byte(hist_mem[wr_ptr - ref_dist[11:0]]);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eoi);
    if (done) return;
    if (hdr_pos < lzfd_pkg::HeaderLen) begin
      if (hdr_pos < 4 && b != lzfd_pkg::magic_byte(hdr_pos[1:0])) begin
        end_stream(lzfd_pkg::StBadMag);
        return;
      end
      if (hdr_pos >= 4 && hdr_pos < 8) out_size = {out_size[23:0], b};
      hdr_pos = hdr_pos + 5'd1;
      if (hdr_pos == lzfd_pkg::HeaderLen && out_size == 0) begin
        end_stream(lzfd_pkg::StOk);
        return;
      end
    end else if (phase == 2'd0) begin
      if (flags_left == 0) begin
        flags = b;
        flags_left = 4'd8;
      end else if (flags[7]) begin
        next_flag();
        append_byte(b);
      end else begin
        tok_first = b;
        phase = 2'd1;
      end
    end else if (phase == 2'd1) begin
      tok_second = b;
      if (tok_first[7:4] != 0) copy_back({28'd0, tok_first[7:4]} + 32'd2);
      else phase = 2'd2;
    end else begin
      copy_back({24'd0, b} + 32'h12);
    end
    if (eoi && !done) end_stream(lzfd_pkg::StTrunc);
  endtask

  always @(posedge clk_i) begin
    out_beat_t exp_b;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        beat_count_o <= beat_count_o + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected beat: data=%h cnt=%0d last=%0b status=%0d",
                   $time, out_bytes_i, byte_count_i, last_i, status_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_b = expected_q.pop_front();
          if (exp_b.data != out_bytes_i || exp_b.cnt != byte_count_i ||
              exp_b.last != last_i || exp_b.st != status_i) begin
            $display("%0t: mismatch: expected data=%h cnt=%0d last=%0b status=%0d",
                     $time, exp_b.data, exp_b.cnt, exp_b.last, exp_b.st);
            $display("%0t:           actual   data=%h cnt=%0d last=%0b status=%0d",
                     $time, out_bytes_i, byte_count_i, last_i, status_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) decode_byte(in_byte_i, end_of_input_i);
    end
  end

endmodule

// ===== test/lz_flag_group_decompressor_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lz_flag_group_decompressor_tb: decompressor testbench
// Feeds one compressed stream (header, literals, short, long and overlapping
// back-references) with random gaps and output stalls, ending on a bad
// reference followed by ignored bytes; the checker scores every output beat.
// ----------------------------------------------------------------------------
module lz_flag_group_decompressor_tb;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
  } in_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = '0;
  logic        end_of_input_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] out_bytes_o;
  logic [3:0]  byte_count_o;
  logic        last_o;
  logic [1:0]  status_o;
  int          fail_count, pending_count, beat_count;

  in_beat_t    stream_q[$];
  int          produced_len = 0;
  int          cycle_cnt = 0;
  int          stall_left = 0;
  logic        quiet_out = 1'b0;

  always #5 clk_i = ~clk_i;

  lz_flag_group_decompressor dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_byte_i, .end_of_input_i,
    .out_valid_o, .out_stall_i, .out_bytes_o, .byte_count_o, .last_o, .status_o
  );

  lzfd_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_byte_i,
    .end_of_input_i, .out_valid_i(out_valid_o), .out_stall_i,
    .out_bytes_i(out_bytes_o), .byte_count_i(byte_count_o), .last_i(last_o),
    .status_i(status_o), .fail_count_o(fail_count),
    .pending_count_o(pending_count), .beat_count_o(beat_count)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 1500000) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // output stall: one random hold-off per accepted beat, with quiet stretches
  always @(posedge clk_i) begin
    if (beat_count % 40 == 0) quiet_out <= ($urandom_range(0, 2) == 0);
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if (out_valid_o && !out_stall_i && !quiet_out) stall_left <= $urandom_range(0, 18);
    end
  end

  task automatic add(input logic [7:0] b, input logic e = 1'b0);
    stream_q.push_back('{data: b, eoi: e});
  endtask

  task automatic add_ref(input int back_dist, input int len);
    logic [11:0] d;
    d = 12'(back_dist - 1);
    if (len <= 17) begin
      add({4'(len - 2), d[11:8]});
      add(d[7:0]);
    end else begin
      add({4'h0, d[11:8]});
      add(d[7:0]);
      add(8'(len - 8'h12));
    end
    produced_len += len;
  endtask

  task automatic add_group();
    logic [7:0] fl;
    int         back_dist[8], len[8];
    for (int i = 0; i < 8; i++) begin
      fl[7 - i] = (produced_len == 0 || produced_len > 3000) ? 1'b1 : 1'($urandom);
      if (!fl[7 - i]) begin
        back_dist[i] = $urandom_range(1, produced_len);
        case ($urandom_range(0, 19))
          0:       len[i] = $urandom_range(18, 273);
          1, 2, 3: len[i] = $urandom_range(18, 60);
          default: len[i] = $urandom_range(3, 17);
        endcase
        produced_len += len[i];
      end else begin
        produced_len += 1;
      end
    end
    add(fl);
    produced_len = produced_len - 0;
    for (int i = 0; i < 8; i++) begin
      if (fl[7 - i]) begin
        add(8'($urandom));
      end else begin
        produced_len -= len[i];
        add_ref(back_dist[i], len[i]);
      end
    end
  endtask

  task automatic send(input in_beat_t it, input int gap);
    logic st;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_byte_i      <= it.data;
    end_of_input_i <= it.eoi;
    do begin
      @(negedge clk_i);
      st = in_stall_o;
      @(posedge clk_i);
    end while (st);
  endtask

  initial begin
    int  gap;
    logic quiet_in;
    // header: magic, size 0x10000000, reserved bytes
    add(8'h59); add(8'h61); add(8'h7A); add(8'h30);
    add(8'h10); add(8'h00); add(8'h00); add(8'h00);
    for (int i = 0; i < 8; i++) add(8'($urandom));
    // literal extremes
    add(8'hFF);
    add(8'hFF); add(8'h00); add(8'hFF);
    for (int i = 0; i < 5; i++) add(8'($urandom));
    produced_len = 8;
    // references: overlap, nibble max, long min, long max, far back
    add(8'h00);
    add_ref(1, 3); add_ref(8, 17); add_ref(16, 18); add_ref(5, 273);
    add_ref(produced_len, 4); add_ref(1, 100); add_ref(2, 20); add_ref(3, 3);
    while (stream_q.size() < 370) add_group();
    // bad reference ends the stream; the rest is ignored
    add(8'h00);
    add(8'h1F); add(8'hFF);
    add(8'($urandom), 1'b1); add(8'($urandom), 1'b0); add(8'hA5, 1'b1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    quiet_in = 1'b0;
    for (int i = 0; i < stream_q.size(); i++) begin
      if (i % 40 == 0) quiet_in = ($urandom_range(0, 2) == 0);
      gap = quiet_in ? 0 : $urandom_range(0, 18);
      if (i == 150) begin
        in_valid_i <= 1'b0;
        while (pending_count != 0) @(posedge clk_i);
        gap = 0;
      end
      send(stream_q[i], gap);
    end
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    $display("sent %0d compressed bytes (%0d bytes of output data), checked %0d beats",
             stream_q.size(), produced_len, beat_count);
    $display("stream closed by an out-of-range reference, trailing bytes ignored");
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== lz_flag_group_decompressor.f =====
hdl/lzfd_pkg.sv
hdl/lzfd_window.sv
hdl/lz_flag_group_decompressor.sv
hdl/lzfd_checker.sv
test/lzfd_checker.sv
test/lz_flag_group_decompressor_tb.sv
